// ===== hw/rtl/slpp_pkg.sv =====
package slpp_pkg;

   localparam int MAX_PARTS = 32;
   localparam int PART_W    = $clog2(MAX_PARTS);
   localparam int PCOUNT_W  = $clog2(MAX_PARTS + 1);

   localparam logic [7:0] MAX_PART_BYTE = 8'(MAX_PARTS);

   localparam logic [1:0] ACTION_DATA    = 2'd0;
   localparam logic [1:0] ACTION_END     = 2'd1;
   localparam logic [1:0] ACTION_REFRESH = 2'd2;

   localparam logic [31:0] CODE_BANNED   = 32'd3;
   localparam logic [31:0] CODE_WAIT     = 32'd4;
   localparam logic [31:0] CODE_OUTDATED = 32'd5;
   localparam logic [31:0] CODE_PARTS    = 32'd6;

   localparam logic [7:0] MARK_PART_END = 8'd7;
   localparam logic [7:0] MARK_LIST_END = 8'd2;

   localparam logic KIND_SERVER  = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [2:0] VERDICT_GOOD     = 3'd0;
   localparam logic [2:0] VERDICT_PENDING  = 3'd1;
   localparam logic [2:0] VERDICT_BANNED   = 3'd2;
   localparam logic [2:0] VERDICT_WAIT     = 3'd3;
   localparam logic [2:0] VERDICT_OUTDATED = 3'd4;
   localparam logic [2:0] VERDICT_BAD      = 3'd5;

   typedef enum logic [3:0] {
      PH_CODE,
      PH_PART,
      PH_MARK,
      PH_COUNT,
      PH_IP,
      PH_PLO,
      PH_PHI,
      PH_FINAL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] server_ip;
      logic [15:0] server_port;
      logic [2:0]  verdict;
   } rsp_type;

endpackage

// ===== hw/rtl/server_list_packet_parser_unit.sv =====
// Server list reply parser: takes one decoded reply byte, end-of-packet or refresh request per
// cycle and gives at most one result (server entry or packet verdict) for each, in the cycle
// after acceptance, from a single result register. A request is accepted in every cycle while
// that register is empty or being taken; a held result stalls requests until rsp_ready. Part
// tracking (bitmap of MAX_PARTS bits) survives end of packet; only refresh or reset clears it.
module server_list_packet_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slpp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slpp_pkg::rsp_type rsp_data
);
   import slpp_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [1:0]            byte_index_ff, byte_index_in;
   logic [31:0]           response_word_ff, response_word_in;
   logic [MAX_PARTS-1:0]  parts_seen_ff, parts_seen_in;
   logic [PCOUNT_W-1:0]   parts_expected_ff, parts_expected_in;
   logic                  final_part_seen_ff, final_part_seen_in;
   logic [7:0]            ports_left_ff, ports_left_in;
   logic [31:0]           held_ip_ff, held_ip_in;
   logic [7:0]            port_low_ff, port_low_in;
   logic                  decided_ff, decided_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  emit;
   logic [7:0]            b;
   logic [31:0]           word;
   logic [PART_W-1:0]     part_num;
   logic [MAX_PARTS-1:0]  part_bit;
   logic [MAX_PARTS-1:0]  all_mask;
   logic [PCOUNT_W-1:0]   part_count;
   logic                  final_now;
   logic [7:0]            ports_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b          = req_data.data_byte;
   assign word       = response_word_ff | (32'(b) << {byte_index_ff, 3'b000});
   assign part_num   = b[PART_W-1:0];
   assign part_bit   = MAX_PARTS'(1) << part_num;
   assign part_count = PCOUNT_W'({1'b0, part_num}) + PCOUNT_W'(1);
   assign ports_dec  = ports_left_ff - 8'd1;

   always_comb begin
      for (int i = 0; i < MAX_PARTS; i++) begin
         all_mask[i] = PCOUNT_W'(i) < parts_expected_ff;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      byte_index_in      = byte_index_ff;
      response_word_in   = response_word_ff;
      parts_seen_in      = parts_seen_ff;
      parts_expected_in  = parts_expected_ff;
      final_part_seen_in = final_part_seen_ff;
      ports_left_in      = ports_left_ff;
      held_ip_in         = held_ip_ff;
      port_low_in        = port_low_ff;
      decided_in         = decided_ff;
      emit               = 1'b0;
      final_now          = final_part_seen_ff || (b == MARK_LIST_END);
      rsp_in             = '{kind: KIND_VERDICT, server_ip: '0, server_port: '0,
                             verdict: VERDICT_PENDING};

      if (accept) begin
         case (req_data.action)
            ACTION_REFRESH: begin
               phase_in           = PH_CODE;
               byte_index_in      = '0;
               response_word_in   = '0;
               parts_seen_in      = '0;
               parts_expected_in  = '0;
               final_part_seen_in = 1'b0;
               ports_left_in      = '0;
               held_ip_in         = '0;
               port_low_in        = '0;
               decided_in         = 1'b0;
            end
            ACTION_END: begin
               phase_in         = PH_CODE;
               byte_index_in    = '0;
               response_word_in = '0;
               ports_left_in    = '0;
               held_ip_in       = '0;
               port_low_in      = '0;
               decided_in       = 1'b0;
               emit             = !decided_ff;
               rsp_in.verdict   = VERDICT_BAD;
            end
            ACTION_DATA: begin
               case (phase_ff)
                  PH_CODE: begin
                     response_word_in = word;
                     if (byte_index_ff != 2'd3) begin
                        byte_index_in = byte_index_ff + 2'd1;
                     end else begin
                        byte_index_in = '0;
                        if (word == CODE_PARTS) begin
                           phase_in = PH_PART;
                        end else begin
                           emit = 1'b1;
                           if (word == CODE_BANNED)        rsp_in.verdict = VERDICT_BANNED;
                           else if (word == CODE_WAIT)     rsp_in.verdict = VERDICT_WAIT;
                           else if (word == CODE_OUTDATED) rsp_in.verdict = VERDICT_OUTDATED;
                           else                            rsp_in.verdict = VERDICT_PENDING;
                        end
                     end
                  end
                  PH_PART: begin
                     if (b >= MAX_PART_BYTE) begin
                        emit           = 1'b1;
                        rsp_in.verdict = VERDICT_BAD;
                     end else if ((parts_seen_ff & part_bit) != '0) begin
                        emit           = 1'b1;
                        rsp_in.verdict = VERDICT_PENDING;
                     end else begin
                        parts_seen_in = parts_seen_ff | part_bit;
                        if (part_count > parts_expected_ff) begin
                           parts_expected_in = part_count;
                        end
                        phase_in = PH_MARK;
                     end
                  end
                  PH_MARK: begin
                     if (b == MARK_PART_END || b == MARK_LIST_END) begin
                        emit               = 1'b1;
                        final_part_seen_in = final_now;
                        rsp_in.verdict     = (final_now && parts_seen_ff == all_mask) ?
                                             VERDICT_GOOD : VERDICT_PENDING;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
                  PH_COUNT: begin
                     if (b == 8'd0) begin
                        phase_in = PH_FINAL;
                     end else begin
                        ports_left_in = b;
                        held_ip_in    = '0;
                        byte_index_in = '0;
                        phase_in      = PH_IP;
                     end
                  end
                  PH_IP: begin
                     held_ip_in = {held_ip_ff[23:0], b};
                     if (byte_index_ff != 2'd3) begin
                        byte_index_in = byte_index_ff + 2'd1;
                     end else begin
                        byte_index_in = '0;
                        phase_in      = PH_PLO;
                     end
                  end
                  PH_PLO: begin
                     port_low_in = b;
                     phase_in    = PH_PHI;
                  end
                  PH_PHI: begin
                     emit   = 1'b1;
                     rsp_in = '{kind: KIND_SERVER, server_ip: held_ip_ff,
                                server_port: {b, port_low_ff}, verdict: VERDICT_GOOD};
                     if (ports_left_ff != 8'd0) begin
                        ports_left_in = ports_dec;
                        phase_in      = (ports_dec == 8'd0) ? PH_COUNT : PH_PLO;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
                  PH_FINAL: begin
                     emit               = 1'b1;
                     final_part_seen_in = final_now;
                     rsp_in.verdict     = (final_now && parts_seen_ff == all_mask) ?
                                          VERDICT_GOOD : VERDICT_PENDING;
                  end
                  default: begin
                  end
               endcase
               if (emit && rsp_in.kind == KIND_VERDICT) begin
                  phase_in   = PH_DONE;
                  decided_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_CODE;
         byte_index_ff      <= '0;
         response_word_ff   <= '0;
         parts_seen_ff      <= '0;
         parts_expected_ff  <= '0;
         final_part_seen_ff <= 1'b0;
         ports_left_ff      <= '0;
         held_ip_ff         <= '0;
         port_low_ff        <= '0;
         decided_ff         <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         byte_index_ff      <= byte_index_in;
         response_word_ff   <= response_word_in;
         parts_seen_ff      <= parts_seen_in;
         parts_expected_ff  <= parts_expected_in;
         final_part_seen_ff <= final_part_seen_in;
         ports_left_ff      <= ports_left_in;
         held_ip_ff         <= held_ip_in;
         port_low_ff        <= port_low_in;
         decided_ff         <= decided_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_decided_done: assert property (@(posedge clock) disable iff (reset)
      decided_ff == (phase_ff == PH_DONE))
      else $error("decided flag and done phase disagree");

   a_parts_in_range: assert property (@(posedge clock) disable iff (reset)
      (parts_seen_ff & ~all_mask) == '0)
      else $error("part seen above expected count");

   a_refresh_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACTION_REFRESH |=>
         parts_seen_ff == '0 && !final_part_seen_ff && !rsp_valid_ff)
      else $error("refresh did not clear tracking");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACTION_END |=> phase_ff == PH_CODE && !decided_ff)
      else $error("end of packet did not restart parser");

   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_VERDICT |->
         rsp_ff.server_ip == '0 && rsp_ff.server_port == '0)
      else $error("verdict carries server fields");
`endif

endmodule
